[design/ppls_pkg.sv]
// Shared constants, register codes and a helper function for the point-light shading pipeline.
// Used by ppls_isqrt, ppls_div and phong_point_light_shading; depends on nothing.
`timescale 1ns / 1ps

package ppls_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_LIGHT_POS = 3'd0,
    CFG_LIGHT_INT = 3'd1,
    CFG_EYE_POS   = 3'd2,
    CFG_ATT_CONST = 3'd3,
    CFG_ATT_LIN   = 3'd4,
    CFG_ATT_QUAD  = 3'd5
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // Integer square root unit: two radicand bits per stage.
  localparam int unsigned SQ_IN_W  = 58;
  localparam int unsigned SQ_OUT_W = SQ_IN_W / 2;
  localparam int unsigned SQ_REM_W = SQ_OUT_W + 3;

  // Divider unit: one quotient bit per stage, quotient saturates at all ones.
  localparam int unsigned DIV_N_W   = 64;
  localparam int unsigned DIV_D_W   = 57;
  localparam int unsigned DIV_Q_W   = 16;
  localparam int unsigned DIV_CMP_W = DIV_D_W + DIV_Q_W;

  localparam int unsigned EXP_W    = 8;
  localparam int unsigned Q14_W    = 15;
  localparam logic [Q14_W-1:0] ONE_Q14 = 15'd16384;
  localparam logic [29:0] HALF_Q14 = 30'd8192;

  // Pipeline depth from the input register to the last divider stage.
  localparam int unsigned FRONT_STAGES = 7;
  localparam int unsigned PIPE_DEPTH =
    FRONT_STAGES + SQ_OUT_W + 2 + DIV_Q_W + EXP_W + 1 + DIV_Q_W;

  // Shift right by 22 with rounding half away from zero.
  function automatic logic signed [28:0] shr_round22(input logic signed [49:0] v);
    logic [49:0] mag;
    logic [49:0] rnd;
    logic [28:0] r;
    mag = v[49] ? 50'(-v) : 50'(v);
    rnd = mag + 50'(1 << 21);
    r   = 29'(rnd[50-1:22]);
    return v[49] ? $signed(29'(-r)) : $signed(r);
  endfunction

endpackage

[design/phong_point_light_shading.sv]
// Top level of the point-light Phong shading pipeline with distance attenuation.
// Depends on ppls_pkg, ppls_isqrt and ppls_div.
`timescale 1ns / 1ps

// Channel   | Handshake               | Payload
// ----------+-------------------------+-----------------------------------------------
// input     | in_valid_i / in_stall_o | mode, point, normal, coef, shininess
// output    | out_valid_o/out_stall_i | out_red, out_green, out_blue, degenerate
// config    | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item enters per cycle while the input is not stalled; each item passes PIPE_DEPTH stages (79)
// in the pipeline and then the output register.
// Most of the depth comes from the square root units, which run in parallel, and the two divider chains.
// Reset clears the valid bits and the output valid and sets the configuration registers to their defaults.
// A stalled output holds; the pipeline keeps moving until its last stage holds an item,
// and only then is the input stalled. Configuration writes are always taken.

module phong_point_light_shading (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ppls_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppls_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic signed [15:0]              point_x_i,
  input  logic signed [15:0]              point_y_i,
  input  logic signed [15:0]              point_z_i,
  input  logic signed [15:0]              normal_x_i,
  input  logic signed [15:0]              normal_y_i,
  input  logic signed [15:0]              normal_z_i,
  input  logic [15:0]                     coef_red_i,
  input  logic [15:0]                     coef_green_i,
  input  logic [15:0]                     coef_blue_i,
  input  logic [7:0]                      shininess_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [15:0]                     out_red_o,
  output logic [15:0]                     out_green_o,
  output logic [15:0]                     out_blue_o,
  output logic                            degenerate_o
);

  localparam int unsigned DEPTH = ppls_pkg::PIPE_DEPTH;
  localparam int unsigned NSQ   = ppls_pkg::SQ_OUT_W;
  localparam int unsigned NDIV  = ppls_pkg::DIV_Q_W;
  localparam int unsigned NEXP  = ppls_pkg::EXP_W;
  localparam int unsigned QW    = ppls_pkg::Q14_W;
  localparam int unsigned FRONT_IDX = DEPTH - NDIV - 2;

  // Values carried along the front of the pipeline once the sums exist.
  typedef struct packed {
    logic               mode;
    logic [7:0]         shin;
    logic [33:0]        d2;
    logic [33:0]        vsq;
    logic signed [34:0] ndl;
    logic [2:0][31:0]   p;
  } fe_t;

  typedef struct packed {
    logic               mode;
    logic [7:0]         shin;
    logic signed [34:0] ndl;
    logic signed [47:0] rdotv;
    logic [33:0]        d2;
    logic [2:0][31:0]   p;
  } sb_sq_t;

  typedef struct packed {
    logic             mode;
    logic [7:0]       shin;
    logic             specz;
    logic             pos;
    logic [42:0]      den;
    logic             degen;
    logic [2:0][31:0] p;
  } sb_div_t;

  typedef struct packed {
    logic [7:0]       e;
    logic [42:0]      den;
    logic             degen;
    logic [2:0][31:0] p;
  } sb_pow_t;

  // ---------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------
  logic [47:0] light_pos_q, light_int_q, eye_pos_q;
  logic [15:0] att_c_q, att_l_q, att_q_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_pos_q <= '0;
      light_int_q <= 48'h8000_8000_8000;
      eye_pos_q   <= '0;
      att_c_q     <= 16'd256;
      att_l_q     <= '0;
      att_q_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (ppls_pkg::cfg_idx_e'(cfg_index_i))
        ppls_pkg::CFG_LIGHT_POS: light_pos_q <= cfg_data_i;
        ppls_pkg::CFG_LIGHT_INT: light_int_q <= cfg_data_i;
        ppls_pkg::CFG_EYE_POS:   eye_pos_q   <= cfg_data_i;
        ppls_pkg::CFG_ATT_CONST: att_c_q     <= cfg_data_i[15:0];
        ppls_pkg::CFG_ATT_LIN:   att_l_q     <= cfg_data_i[15:0];
        ppls_pkg::CFG_ATT_QUAD:  att_q_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------
  // Flow control: all stages advance together. The output register parts the two
  // sides, so a bubble in the last stage still lets the pipeline move under a stall.
  // ---------------------------------------------------------------------------------
  logic [DEPTH-1:0] vld_q;
  logic             out_v_q;
  logic             out_load;
  logic             en;

  assign out_load   = !out_v_q || !out_stall_i;
  assign en         = out_load || !vld_q[DEPTH-1];
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------------
  // Stage 1: vectors to the light and to the eye.
  // ---------------------------------------------------------------------------------
  logic [2:0][15:0] pt, nrm, coef;
  assign pt   = {point_z_i, point_y_i, point_x_i};
  assign nrm  = {normal_z_i, normal_y_i, normal_x_i};
  assign coef = {coef_blue_i, coef_green_i, coef_red_i};

  logic signed [16:0] s1_lv_q [3];
  logic signed [16:0] s1_vv_q [3];
  logic signed [15:0] s1_nv_q [3];
  logic [15:0]        s1_coef_q [3];
  logic               s1_mode_q;
  logic [7:0]         s1_shin_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_lv_q[i]   <= $signed({light_pos_q[16*i+15], light_pos_q[16*i +: 16]})
                      - $signed({pt[i][15], pt[i]});
        s1_vv_q[i]   <= $signed({eye_pos_q[16*i+15], eye_pos_q[16*i +: 16]})
                      - $signed({pt[i][15], pt[i]});
        s1_nv_q[i]   <= $signed(nrm[i]);
        s1_coef_q[i] <= coef[i];
      end
      s1_mode_q <= mode_i;
      s1_shin_q <= shininess_i;
    end
  end

  // Stage 2: squares, normal products and intensity times material color.
  logic [31:0]        s2_lsq_q [3];
  logic [31:0]        s2_vsq_q [3];
  logic signed [32:0] s2_nl_q  [3];
  logic [2:0][31:0]   s2_p_q;
  logic signed [16:0] s2_lv_q  [3];
  logic signed [16:0] s2_vv_q  [3];
  logic signed [15:0] s2_nv_q  [3];
  logic               s2_mode_q;
  logic [7:0]         s2_shin_q;

  logic signed [33:0] lsq_w [3];
  logic signed [33:0] vsq_w [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lsq_w[i] = s1_lv_q[i] * s1_lv_q[i];
      vsq_w[i] = s1_vv_q[i] * s1_vv_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_lsq_q[i] <= lsq_w[i][31:0];
        s2_vsq_q[i] <= vsq_w[i][31:0];
        s2_nl_q[i]  <= s1_nv_q[i] * s1_lv_q[i];
        s2_p_q[i]   <= light_int_q[16*i +: 16] * s1_coef_q[i];
        s2_lv_q[i]  <= s1_lv_q[i];
        s2_vv_q[i]  <= s1_vv_q[i];
        s2_nv_q[i]  <= s1_nv_q[i];
      end
      s2_mode_q <= s1_mode_q;
      s2_shin_q <= s1_shin_q;
    end
  end

  // Stage 3: squared distances and the dot product of normal and light vector.
  fe_t                s3_q, s4_q, s5_q, s6_q, s7_q;
  logic signed [16:0] s3_lv_q [3];
  logic signed [16:0] s3_vv_q [3];
  logic signed [15:0] s3_nv_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q.mode <= s2_mode_q;
      s3_q.shin <= s2_shin_q;
      s3_q.d2   <= 34'(s2_lsq_q[0]) + 34'(s2_lsq_q[1]) + 34'(s2_lsq_q[2]);
      s3_q.vsq  <= 34'(s2_vsq_q[0]) + 34'(s2_vsq_q[1]) + 34'(s2_vsq_q[2]);
      s3_q.ndl  <= 35'(s2_nl_q[0]) + 35'(s2_nl_q[1]) + 35'(s2_nl_q[2]);
      s3_q.p    <= s2_p_q;
      for (int i = 0; i < 3; i++) begin
        s3_lv_q[i] <= s2_lv_q[i];
        s3_vv_q[i] <= s2_vv_q[i];
        s3_nv_q[i] <= s2_nv_q[i];
      end
    end
  end

  // Stage 4: twice the dot product times each normal component.
  logic signed [49:0] s4_m_q  [3];
  logic signed [16:0] s4_lv_q [3];
  logic signed [16:0] s4_vv_q [3];
  logic signed [49:0] m_w     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_w[i] = s3_q.ndl * s3_nv_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q <= s3_q;
      for (int i = 0; i < 3; i++) begin
        s4_m_q[i]  <= m_w[i] <<< 1;
        s4_lv_q[i] <= s3_lv_q[i];
        s4_vv_q[i] <= s3_vv_q[i];
      end
    end
  end

  // Stage 5: reflection vector at scale 2^6 (one LSB is 2^-6 of a raw unit).
  logic signed [28:0] s5_rv_q [3];
  logic signed [16:0] s5_vv_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q <= s4_q;
      for (int i = 0; i < 3; i++) begin
        s5_rv_q[i] <= ppls_pkg::shr_round22(s4_m_q[i]) - (29'(s4_lv_q[i]) <<< 6);
        s5_vv_q[i] <= s4_vv_q[i];
      end
    end
  end

  // Stage 6: reflection squares and reflection-view products.
  logic [55:0]        s6_rr_q  [3];
  logic signed [45:0] s6_rdv_q [3];
  logic signed [57:0] rr_w     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rr_w[i] = s5_rv_q[i] * s5_rv_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q <= s5_q;
      for (int i = 0; i < 3; i++) begin
        s6_rr_q[i]  <= rr_w[i][55:0];
        s6_rdv_q[i] <= s5_rv_q[i] * s5_vv_q[i];
      end
    end
  end

  // Stage 7: sums that feed the square root units.
  logic [ppls_pkg::SQ_IN_W-1:0] s7_rsq_q;
  logic signed [47:0]           s7_rdotv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_q       <= s6_q;
      s7_rsq_q   <= ppls_pkg::SQ_IN_W'(s6_rr_q[0]) + ppls_pkg::SQ_IN_W'(s6_rr_q[1])
                  + ppls_pkg::SQ_IN_W'(s6_rr_q[2]);
      s7_rdotv_q <= 48'(s6_rdv_q[0]) + 48'(s6_rdv_q[1]) + 48'(s6_rdv_q[2]);
    end
  end

  // ---------------------------------------------------------------------------------
  // Square roots of the light distance, the reflection length and the view length.
  // ---------------------------------------------------------------------------------
  logic [NSQ-1:0] d_w, rm_w, vm_w;

  ppls_isqrt u_sqrt_d (
    .clk_i      (clk_i),
    .en_i       (en),
    .radicand_i (ppls_pkg::SQ_IN_W'(s7_q.d2)),
    .root_o     (d_w)
  );

  ppls_isqrt u_sqrt_r (
    .clk_i      (clk_i),
    .en_i       (en),
    .radicand_i (s7_rsq_q),
    .root_o     (rm_w)
  );

  ppls_isqrt u_sqrt_v (
    .clk_i      (clk_i),
    .en_i       (en),
    .radicand_i (ppls_pkg::SQ_IN_W'(s7_q.vsq)),
    .root_o     (vm_w)
  );

  sb_sq_t sb_sq_q [NSQ];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_sq_q[0] <= '{mode: s7_q.mode, shin: s7_q.shin, ndl: s7_q.ndl,
                      rdotv: s7_rdotv_q, d2: s7_q.d2, p: s7_q.p};
      for (int k = 1; k < NSQ; k++) begin
        sb_sq_q[k] <= sb_sq_q[k-1];
      end
    end
  end

  // Stage 8: attenuation products and the length product.
  sb_sq_t      s8_q;
  logic [32:0] s8_ld_q;
  logic [49:0] s8_qd2_q;
  logic [45:0] s8_dd_q;
  logic [16:0] s8_d_q;
  logic        s8_specz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q       <= sb_sq_q[NSQ-1];
      s8_ld_q    <= att_l_q * d_w[16:0];
      s8_qd2_q   <= att_q_q * sb_sq_q[NSQ-1].d2;
      s8_dd_q    <= rm_w * vm_w[16:0];
      s8_d_q     <= d_w[16:0];
      // A zero reflection or the eye on the point gives no specular light.
      s8_specz_q <= (rm_w == '0) || (vm_w == '0);
    end
  end

  // Stage 9: attenuation denominator and the operands of the cosine division.
  logic [50:0]               qd2_rnd;
  logic [42:0]               den_w;
  sb_div_t                   s9_q;
  logic [ppls_pkg::DIV_N_W-1:0] s9_num_q;
  logic [ppls_pkg::DIV_D_W-1:0] s9_dvs_q;

  assign qd2_rnd = 51'(s8_qd2_q) + 51'd128;
  assign den_w   = 43'({att_c_q, 8'h00}) + 43'(s8_ld_q) + qd2_rnd[50:8];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_q.mode  <= s8_q.mode;
      s9_q.shin  <= s8_q.shin;
      s9_q.specz <= s8_specz_q;
      s9_q.pos   <= s8_q.mode ? (s8_q.rdotv > 0) : (s8_q.ndl > 0);
      s9_q.den   <= den_w;
      s9_q.degen <= (s8_q.d2 == '0) || (den_w == '0);
      s9_q.p     <= s8_q.p;
      if (s8_q.mode) begin
        s9_num_q <= (ppls_pkg::DIV_N_W'($unsigned(s8_q.rdotv)) << 14)
                  + ppls_pkg::DIV_N_W'(s8_dd_q >> 1);
        s9_dvs_q <= ppls_pkg::DIV_D_W'(s8_dd_q);
      end else begin
        s9_num_q <= ppls_pkg::DIV_N_W'($unsigned(s8_q.ndl))
                  + ppls_pkg::DIV_N_W'(s8_d_q >> 1);
        s9_dvs_q <= ppls_pkg::DIV_D_W'(s8_d_q);
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Cosine division: dot product over the lengths, Q1.14.
  // ---------------------------------------------------------------------------------
  logic [NDIV-1:0] cos_w;
  sb_div_t         sb_div_q [NDIV];

  ppls_div u_div_cos (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (s9_num_q),
    .den_i  (s9_dvs_q),
    .quot_o (cos_w)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_div_q[0] <= s9_q;
      for (int k = 1; k < NDIV; k++) begin
        sb_div_q[k] <= sb_div_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Power by square and multiply, one exponent bit per stage from the low end.
  // Diffuse items use a zero exponent so the factor passes through unchanged.
  // ---------------------------------------------------------------------------------
  sb_div_t     cd;
  logic [QW-1:0] cos_cap, acc0, base0;

  assign cd      = sb_div_q[NDIV-1];
  assign cos_cap = (cos_w > NDIV'(ppls_pkg::ONE_Q14)) ? ppls_pkg::ONE_Q14 : cos_w[QW-1:0];
  assign base0   = cd.pos ? cos_cap : '0;
  assign acc0    = cd.mode ? (cd.specz ? '0 : ppls_pkg::ONE_Q14) : base0;

  logic [QW-1:0] pw_acc_q  [NEXP];
  logic [QW-1:0] pw_base_q [NEXP];
  sb_pow_t       pw_sb_q   [NEXP];

  for (genvar j = 0; j < NEXP; j++) begin : g_pow
    logic [QW-1:0] acc_in, base_in;
    sb_pow_t       sb_in;
    logic [29:0]   pa, pb;

    if (j == 0) begin : g_first
      assign acc_in  = acc0;
      assign base_in = base0;
      assign sb_in   = '{e: cd.mode ? cd.shin : 8'h00, den: cd.den, degen: cd.degen,
                         p: cd.p};
    end else begin : g_next
      assign acc_in  = pw_acc_q[j-1];
      assign base_in = pw_base_q[j-1];
      assign sb_in   = pw_sb_q[j-1];
    end

    assign pa = acc_in * base_in + ppls_pkg::HALF_Q14;
    assign pb = base_in * base_in + ppls_pkg::HALF_Q14;

    always_ff @(posedge clk_i) begin
      if (en) begin
        pw_acc_q[j]  <= sb_in.e[j] ? pa[14 +: QW] : acc_in;
        pw_base_q[j] <= pb[14 +: QW];
        pw_sb_q[j]   <= sb_in;
      end
    end
  end

  // Stage after the power: scale each channel product by the factor.
  logic [46:0] sp_prod_q [3];
  logic [42:0] sp_den_q;
  logic        sp_degen_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sp_prod_q[i] <= pw_sb_q[NEXP-1].p[i] * pw_acc_q[NEXP-1];
      end
      sp_den_q   <= pw_sb_q[NEXP-1].den;
      sp_degen_q <= pw_sb_q[NEXP-1].degen;
    end
  end

  // ---------------------------------------------------------------------------------
  // Color division by den * 2^13 with rounding; quotients saturate at full scale.
  // ---------------------------------------------------------------------------------
  logic [NDIV-1:0] col_w [3];

  for (genvar i = 0; i < 3; i++) begin : g_col
    ppls_div u_div_col (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (ppls_pkg::DIV_N_W'(sp_prod_q[i]) + ppls_pkg::DIV_N_W'({sp_den_q, 12'h000})),
      .den_i  (ppls_pkg::DIV_D_W'({sp_den_q, 13'h0000})),
      .quot_o (col_w[i])
    );
  end

  logic [NDIV-1:0] degen_dly_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      degen_dly_q <= {degen_dly_q[NDIV-2:0], sp_degen_q};
    end
  end

  // ---------------------------------------------------------------------------------
  // Output register. A degenerate item (point on the light, or zero denominator)
  // comes out flagged with a black color.
  // ---------------------------------------------------------------------------------
  logic        last_degen;
  logic [15:0] out_red_q, out_green_q, out_blue_q;
  logic        out_degen_q;

  assign last_degen = degen_dly_q[NDIV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= vld_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_red_q   <= last_degen ? '0 : col_w[0];
      out_green_q <= last_degen ? '0 : col_w[1];
      out_blue_q  <= last_degen ? '0 : col_w[2];
      out_degen_q <= last_degen;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_red_o    = out_red_q;
  assign out_green_o  = out_green_q;
  assign out_blue_o   = out_blue_q;
  assign degenerate_o = out_degen_q;

  // ---------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------
  a_degen_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      (out_red_o == '0) && (out_green_o == '0) && (out_blue_o == '0))
    else $error("degenerate result carries a nonzero color");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && vld_q[DEPTH-1])
    else $error("input stalled while the pipeline could move");

  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[FRONT_IDX] |-> pw_acc_q[NEXP-1] <= ppls_pkg::ONE_Q14)
    else $error("shading factor above one");

endmodule

[design/ppls_isqrt.sv]
// Pipelined integer square root, one root bit per register stage.
// Depends on ppls_pkg for widths.
`timescale 1ns / 1ps

module ppls_isqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ppls_pkg::SQ_IN_W-1:0]  radicand_i,
  output logic [ppls_pkg::SQ_OUT_W-1:0] root_o
);

  localparam int unsigned NS = ppls_pkg::SQ_OUT_W;
  localparam int unsigned XW = ppls_pkg::SQ_IN_W;
  localparam int unsigned RW = ppls_pkg::SQ_REM_W;

  logic [XW-1:0] x_q    [NS];
  logic [RW-1:0] rem_q  [NS];
  logic [NS-1:0] root_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [XW-1:0] x_in;
    logic [RW-1:0] rem_in;
    logic [NS-1:0] root_in;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign x_in    = radicand_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_in[RW-3:0], x_in[XW-1:XW-2]};
    assign trial  = RW'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= {x_in[XW-3:0], 2'b00};
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[NS-2:0], ge};
      end
    end
  end

  assign root_o = root_q[NS-1];

endmodule

[design/ppls_div.sv]
// Pipelined restoring divider, one quotient bit per register stage, saturating quotient.
// Depends on ppls_pkg for widths.
`timescale 1ns / 1ps

module ppls_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ppls_pkg::DIV_N_W-1:0] num_i,
  input  logic [ppls_pkg::DIV_D_W-1:0] den_i,
  output logic [ppls_pkg::DIV_Q_W-1:0] quot_o
);

  localparam int unsigned NS = ppls_pkg::DIV_Q_W;
  localparam int unsigned NW = ppls_pkg::DIV_N_W;
  localparam int unsigned DW = ppls_pkg::DIV_D_W;
  localparam int unsigned CW = ppls_pkg::DIV_CMP_W;

  logic [NW-1:0] rem_q [NS];
  logic [DW-1:0] den_q [NS];
  logic [NS-1:0] quo_q [NS];
  logic          ovf_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int unsigned B = NS - 1 - k;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [NS-1:0] quo_in;
    logic          ovf_in;
    logic [CW-1:0] dsh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      // Quotient would not fit: saturate.
      assign ovf_in = (CW'(num_i) >= {den_i, {NS{1'b0}}});
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign ovf_in = ovf_q[k-1];
    end

    assign dsh = CW'(den_in) << B;
    assign ge  = (CW'(rem_in) >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (rem_in - dsh[NW-1:0]) : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= quo_in | (NS'(ge) << B);
        ovf_q[k] <= ovf_in;
      end
    end
  end

  assign quot_o = ovf_q[NS-1] ? '1 : quo_q[NS-1];

endmodule

[verif/tb_phong_point_light_shading.sv]
// Self-checking testbench for the point-light Phong shading pipeline.
// Depends on ppls_pkg and phong_point_light_shading; needs no files or arguments.
`timescale 1ns / 1ps

module tb_phong_point_light_shading;

  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 4000;
  // Extra wait after the last color comes back, before the configuration changes.
  localparam int unsigned DRAIN_WAIT = 100;

  // One surface fragment as presented on the input channel.
  typedef struct {
    logic               mode;
    logic signed [15:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [15:0]        cr, cg, cb;
    logic [7:0]         shin;
  } frag_t;

  // One shaded color as seen on the output channel.
  typedef struct {
    logic [15:0] red, green, blue;
    logic        degen;
  } color_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               mode_i = 1'b0;
  logic signed [15:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic signed [15:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic [15:0]        coef_red_i = '0, coef_green_i = '0, coef_blue_i = '0;
  logic [7:0]         shininess_i = '0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] out_red_o, out_green_o, out_blue_o;
  logic        degenerate_o;

  phong_point_light_shading dut (.*);

  // Shadow copy of the configuration, changed only while the pipeline is empty.
  logic [47:0] light_pos_q, light_int_q, eye_pos_q;
  logic [15:0] att_c_q, att_l_q, att_q_q;

  frag_t  frag_fifo[$];   // fragments waiting to be sent
  color_t color_fifo[$];  // predicted colors in send order
  frag_t  shown;          // fragment currently on the input port

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Bit-by-bit integer square root (floor).
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Arithmetic shift right by 22 with halves rounded away from zero.
  function automatic longint round_shift22(input longint v);
    if (v < 0) return -((-v + (64'sd1 <<< 21)) >>> 22);
    return (v + (64'sd1 <<< 21)) >>> 22;
  endfunction

  // Predicts the shaded color of one fragment under the current configuration.
  function automatic color_t shade(input frag_t f);
    color_t          c;
    longint          pt[3], nv[3], lv[3], rv[3], vv[3];
    longint          ndl, rdv;
    longint unsigned d2, d, den, fac, rsq, vsq, rm, vm, cosv, base, pw, p, q, v;
    int unsigned     e;
    pt[0] = f.px; pt[1] = f.py; pt[2] = f.pz;
    nv[0] = f.nx; nv[1] = f.ny; nv[2] = f.nz;
    d2 = 0; ndl = 0; fac = 0;
    for (int i = 0; i < 3; i++) begin
      lv[i] = longint'($signed(light_pos_q[16*i +: 16])) - pt[i];
      d2 += longint'(lv[i] * lv[i]);
      ndl += nv[i] * lv[i];
    end
    d = int_sqrt(d2);
    den = (longint'(att_c_q) << 8) + longint'(att_l_q) * d + ((longint'(att_q_q) * d2 + 128) >> 8);
    c = '{red: 16'd0, green: 16'd0, blue: 16'd0, degen: 1'b1};
    if (d2 == 0 || den == 0) return c;
    if (!f.mode) begin
      if (ndl > 0) begin
        fac = (longint'(ndl) + d / 2) / d;
        if (fac > 16384) fac = 16384;
      end
    end else begin
      rsq = 0; vsq = 0; rdv = 0;
      e = f.shin;
      for (int i = 0; i < 3; i++) begin
        rv[i] = round_shift22(2 * ndl * nv[i]) - lv[i] * 64;
        vv[i] = longint'($signed(eye_pos_q[16*i +: 16])) - pt[i];
        rsq += longint'(rv[i] * rv[i]);
        vsq += longint'(vv[i] * vv[i]);
        rdv += rv[i] * vv[i];
      end
      rm = int_sqrt(rsq);
      vm = int_sqrt(vsq);
      if (rm != 0 && vm != 0) begin
        cosv = 0;
        if (rdv > 0) begin
          cosv = ((longint'(rdv) << 14) + (rm * vm) / 2) / (rm * vm);
          if (cosv > 16384) cosv = 16384;
        end
        // Square and multiply from the low exponent bit, rounding each product.
        pw = 16384;
        base = cosv;
        while (e != 0) begin
          if (e[0]) pw = (pw * base + 8192) >> 14;
          base = (base * base + 8192) >> 14;
          e >>= 1;
        end
        fac = pw;
      end
    end
    q = den << 13;
    for (int i = 0; i < 3; i++) begin
      p = longint'(light_int_q[16*i +: 16]);
      p = p * longint'(i == 0 ? f.cr : (i == 1 ? f.cg : f.cb)) * fac;
      v = (p + q / 2) / q;
      if (v > 16'hFFFF) v = 16'hFFFF;
      if (i == 0) c.red = v[15:0];
      else if (i == 1) c.green = v[15:0];
      else c.blue = v[15:0];
    end
    c.degen = 1'b0;
    return c;
  endfunction

  // Input driver: a new fragment is offered only once the previous one was taken,
  // so valid never depends on the stall seen in the same cycle.
  always @(posedge clk_i or negedge rst_ni) begin : drive_frags
    frag_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) color_fifo.push_back(shade(shown));
      if (!in_valid_i || !in_stall_o) begin
        if (frag_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = frag_fifo.pop_front();
          shown        <= nxt;
          in_valid_i   <= 1'b1;
          mode_i       <= nxt.mode;
          point_x_i    <= nxt.px;
          point_y_i    <= nxt.py;
          point_z_i    <= nxt.pz;
          normal_x_i   <= nxt.nx;
          normal_y_i   <= nxt.ny;
          normal_z_i   <= nxt.nz;
          coef_red_i   <= nxt.cr;
          coef_green_i <= nxt.cg;
          coef_blue_i  <= nxt.cb;
          shininess_i  <= nxt.shin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random back-pressure and an in-order compare of each color.
  always @(posedge clk_i or negedge rst_ni) begin : check_colors
    color_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (color_fifo.size() == 0) begin
          $error("color arrived with no fragment outstanding");
          err_cnt++;
        end else begin
          want = color_fifo.pop_front();
          if (out_red_o !== want.red) begin
            $error("out_red: expected %0d, got %0d", want.red, out_red_o);
            err_cnt++;
          end
          if (out_green_o !== want.green) begin
            $error("out_green: expected %0d, got %0d", want.green, out_green_o);
            err_cnt++;
          end
          if (out_blue_o !== want.blue) begin
            $error("out_blue: expected %0d, got %0d", want.blue, out_blue_o);
            err_cnt++;
          end
          if (degenerate_o !== want.degen) begin
            $error("degenerate: expected %0b, got %0b", want.degen, degenerate_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input ppls_pkg::cfg_idx_e idx, input logic [47:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      ppls_pkg::CFG_LIGHT_POS: light_pos_q = data;
      ppls_pkg::CFG_LIGHT_INT: light_int_q = data;
      ppls_pkg::CFG_EYE_POS:   eye_pos_q = data;
      ppls_pkg::CFG_ATT_CONST: att_c_q = data[15:0];
      ppls_pkg::CFG_ATT_LIN:   att_l_q = data[15:0];
      default:                 att_q_q = data[15:0];
    endcase
  endtask

  task automatic write_all(input logic [47:0] lp, input logic [47:0] li, input logic [47:0] ep,
                           input logic [15:0] ac, input logic [15:0] al, input logic [15:0] aq);
    write_reg(ppls_pkg::CFG_LIGHT_POS, lp);
    write_reg(ppls_pkg::CFG_LIGHT_INT, li);
    write_reg(ppls_pkg::CFG_EYE_POS, ep);
    write_reg(ppls_pkg::CFG_ATT_CONST, {32'd0, ac});
    write_reg(ppls_pkg::CFG_ATT_LIN, {32'd0, al});
    write_reg(ppls_pkg::CFG_ATT_QUAD, {32'd0, aq});
  endtask

  task automatic add_frag(input logic m, input int px, input int py, input int pz,
                          input int nx, input int ny, input int nz,
                          input int cr, input int cg, input int cb, input int sh);
    frag_t f;
    f = '{mode: m, px: px[15:0], py: py[15:0], pz: pz[15:0], nx: nx[15:0], ny: ny[15:0],
          nz: nz[15:0], cr: cr[15:0], cg: cg[15:0], cb: cb[15:0], shin: sh[7:0]};
    frag_fifo.push_back(f);
  endtask

  function automatic int rand_coord();
    if ($urandom_range(7) == 0) return int'($signed(16'($urandom())));
    return $urandom_range(8191) - 4096;
  endfunction

  function automatic int rand_norm();
    return $urandom_range(32768) - 16384;
  endfunction

  // Near-unit normals along an axis or a diagonal half the time, arbitrary ones otherwise.
  task automatic add_random_frag();
    int n[3];
    int k;
    k = $urandom_range(3);
    for (int i = 0; i < 3; i++) n[i] = rand_norm();
    if (k == 0) begin
      n = '{0, 0, 0};
      n[$urandom_range(2)] = $urandom_range(1) ? 16384 : -16384;
    end else if (k == 1) begin
      for (int i = 0; i < 3; i++) n[i] = $urandom_range(1) ? 9459 : -9459;
    end
    add_frag($urandom_range(1), rand_coord(), rand_coord(), rand_coord(), n[0], n[1], n[2],
             $urandom_range(32768), $urandom_range(32768), $urandom_range(32768),
             $urandom_range(3) == 0 ? $urandom_range(8) : $urandom_range(255));
  endtask

  function automatic logic [47:0] rand_pos();
    return {16'($urandom_range(4095) - 2048), 16'($urandom_range(4095) - 2048),
            16'($urandom_range(4095) - 2048)};
  endfunction

  // Wait until every fragment was sent and every color came back, then let the
  // pipeline settle before configuration changes.
  task automatic drain();
    while (frag_fifo.size() != 0 || in_valid_i || color_fifo.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  initial begin
    light_pos_q = '0;
    light_int_q = 48'h8000_8000_8000;
    eye_pos_q   = '0;
    att_c_q = 16'd256;
    att_l_q = '0;
    att_q_q = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      case (ph)
        0: write_all('0, 48'h8000_8000_8000, '0, 16'd256, 16'd0, 16'd0);
        1: write_all(48'h0001_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h0300_0200_0100,
                     16'd256, 16'd0, 16'd0);
        // All attenuation terms zero: every fragment is degenerate.
        2: write_all(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h7FFF_8000_7FFF,
                     16'd0, 16'd0, 16'd0);
        3: write_all(48'h8000_7FFF_8000, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Tiny denominator with full intensity drives the colors into saturation.
        4: write_all(rand_pos(), 48'hFFFF_FFFF_FFFF, rand_pos(), 16'd1, 16'd0, 16'd0);
        default: write_all(rand_pos(), {$urandom(), 16'($urandom())}, rand_pos(),
                           16'($urandom_range(1024)), 16'($urandom_range(64)),
                           16'($urandom_range(16)));
      endcase

      if (ph == 1) begin
        // Light at one raw unit above the origin, eye away from the origin.
        add_frag(0, 0, 0, 0, 0, 0, 16384, 32768, 32768, 32768, 0);
        add_frag(1, 0, 0, 0, 0, 0, 16384, 32768, 32768, 32768, 1);
        // Normal chosen so that the reflection vector vanishes.
        add_frag(1, 0, 0, 0, 0, 0, 11585, 32768, 32768, 32768, 200);
        // Eye sitting on the point.
        add_frag(1, 256, 512, 768, 16384, 0, 0, 32768, 32768, 32768, 5);
        // Point on the light, both modes.
        add_frag(0, 0, 0, 1, 0, 0, 16384, 32768, 32768, 32768, 0);
        add_frag(1, 0, 0, 1, 0, 0, 16384, 32768, 32768, 32768, 255);
        // Coordinate and field extremes.
        add_frag(0, -32768, -32768, -32768, 16384, 16384, 16384, 32768, 0, 32768, 255);
        add_frag(1, 32767, 32767, 32767, -16384, -16384, -16384, 0, 32768, 0, 255);
        add_frag(1, -32768, 32767, -32768, -16384, 16384, -16384, 32768, 32768, 32768, 0);
        add_frag(0, 32767, -32768, 0, 16384, -16384, 16384, 1, 1, 1, 128);
        // Overlong normal: the diffuse cosine reaches the cap of one.
        add_frag(0, 0, 0, -256, 16384, 16384, 16384, 32768, 32768, 32768, 0);
        add_frag(1, 0, 0, -256, 16384, 16384, 16384, 32768, 32768, 32768, 1);
        // Back-facing surface and a zero normal.
        add_frag(0, 0, 0, 256, 0, 0, 16384, 32768, 32768, 32768, 0);
        add_frag(1, 0, 0, 256, 0, 0, 0, 32768, 32768, 32768, 3);
        add_frag(1, 1024, -768, 300, 0, 16384, 0, 20000, 12345, 32767, 2);
        add_frag(1, -100, 100, -50, 9459, 9459, 9459, 32768, 16384, 8192, 64);
      end else begin
        repeat (ph == 2 ? 20 : (ph == 0 ? 60 : 70)) add_random_frag();
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
